// ===== hw/rtl/htdr_pkg.sv =====
// shared types and constants for the direct-mapped hash table
package htdr_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = $clog2(ENTRIES);

    localparam int KEY_W   = 64;
    localparam int SCORE_W = 16;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 16;
    localparam int GEN_W   = 8;
    localparam int OP_W    = 2;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 48;

    localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [BOUND_W-1:0] BOUND_EMPTY = 2'd0;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SCORE_W-1:0] score;
        logic [DEPTH_W-1:0] depth;
        logic [BOUND_W-1:0] bound;
        logic [MOVE_W-1:0]  move;
        logic               move_null;
        logic [GEN_W-1:0]   gen;
    } t_slot;

    typedef struct packed {
        logic load;
        logic commit;
        logic sweep;
    } t_cmd;

    typedef struct packed {
        logic is_clear;
        logic sweep_last;
    } t_sts;

endpackage

// ===== hw/rtl/hash_table_depth_replacement.sv =====
// top level of the direct-mapped hash table with depth-preferred replacement
//
//  channel  | signals                          | carries
//  ---------+----------------------------------+---------------------------------------
//  s        | i_s_tvalid o_s_tready data user  | probe, store or clear request
//  m        | o_m_tvalid i_m_tready o_m_tdata  | one result per request
//  cfg      | i_cfg_valid o_cfg_ready data     | search generation register
//
// probe and store read the slot, then compare and conditionally write
// clear sweeps all ENTRIES (1024) slots of the slot memory after its result is committed
// after reset a sweep of the slot memory runs before the first request is taken
// a result waiting in the output register holds off only the commit of the next request
module hash_table_depth_replacement (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // pos_key, store_score, store_depth, store_bound, store_move, store_move_null
    input  logic [htdr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // op
    input  logic [htdr_pkg::OP_W-1:0]       i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // hit, written, found_score, found_depth, found_bound, found_move, found_move_null
    output logic [htdr_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [htdr_pkg::GEN_W-1:0]      i_cfg_data
);
    import htdr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    htdr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htdr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (o_m_tdata)
    );

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.sweep |-> !o_s_tready)
        else $error("request accepted during clear sweep");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request accepted before lookup finished");

    a_commit_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |=> o_m_tvalid)
        else $error("committed result not presented");

    a_hit_xor_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("result flags both hit and written");

endmodule

// ===== hw/rtl/htdr_ctrl.sv =====
// controller state machine: request handshake, lookup sequencing and clear sweep
module htdr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    input  htdr_pkg::t_sts i_sts,
    output htdr_pkg::t_cmd o_cmd
);
    import htdr_pkg::*;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_LOOKUP = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;

    always_comb begin
        o_cmd.load   = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.commit = (r_state == ST_LOOKUP) && (!r_out_valid || i_m_tready);
        o_cmd.sweep  = (r_state == ST_CLEAR);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (o_cmd.commit) begin
                    n_state = i_sts.is_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

// ===== hw/rtl/htdr_datapath.sv =====
// datapath: slot memory, request registers, replacement decision, result register
module htdr_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  htdr_pkg::t_cmd                  i_cmd,
    output htdr_pkg::t_sts                  o_sts,
    input  logic [htdr_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  logic [htdr_pkg::OP_W-1:0]       i_s_tuser,
    input  logic                            i_cfg_valid,
    input  logic [htdr_pkg::GEN_W-1:0]      i_cfg_data,
    output logic [htdr_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import htdr_pkg::*;

    t_slot r_mem [ENTRIES];
    t_slot r_rd;

    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_key;
    logic [SCORE_W-1:0] r_score;
    logic [DEPTH_W-1:0] r_depth;
    logic [BOUND_W-1:0] r_bound;
    logic [MOVE_W-1:0]  r_move;
    logic               r_move_null;

    logic [GEN_W-1:0]   r_gen;
    logic [IDX_W-1:0]   r_clr_addr, n_clr_addr;
    logic [M_TDATA_W-1:0] r_out, n_out;

    logic        same, occupied, cur_gen, deeper, blocked;
    logic        is_store, is_probe, hit, do_write, keep_move;
    logic        we;
    logic [IDX_W-1:0] wa, ra;
    t_slot       wd, new_slot;

    assign ra = i_s_tdata[IDX_W-1:0];

    // replacement policy
    assign same     = (r_rd.key == r_key);
    assign occupied = (r_rd.bound != BOUND_EMPTY);
    assign cur_gen  = (r_rd.gen == r_gen);
    assign deeper   = $signed(r_depth) < $signed(r_rd.depth);
    assign blocked  = occupied && cur_gen && deeper;
    assign is_store = (r_op == OP_STORE);
    assign is_probe = (r_op == OP_PROBE);
    assign hit      = is_probe && occupied && same;
    assign do_write = is_store && !blocked;
    assign keep_move = r_move_null && same;

    always_comb begin
        new_slot.key       = r_key;
        new_slot.score     = r_score;
        new_slot.depth     = r_depth;
        new_slot.bound     = r_bound;
        new_slot.gen       = r_gen;
        new_slot.move      = keep_move ? r_rd.move : r_move;
        new_slot.move_null = keep_move ? r_rd.move_null : r_move_null;
    end

    always_comb begin
        if (i_cmd.sweep) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = '0;
        end else begin
            we = i_cmd.commit && do_write;
            wa = r_key[IDX_W-1:0];
            wd = new_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (i_cmd.load) begin
            r_rd <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op        <= i_s_tuser;
            r_key       <= i_s_tdata[63:0];
            r_score     <= i_s_tdata[79:64];
            r_depth     <= i_s_tdata[87:80];
            r_bound     <= i_s_tdata[89:88];
            r_move      <= i_s_tdata[105:90];
            r_move_null <= i_s_tdata[106];
        end
    end

    // result word: hit, written, score, depth, bound, move, move_null, zero pad
    always_comb begin
        n_out = '0;
        n_out[0] = hit;
        n_out[1] = do_write;
        if (hit) begin
            n_out[17:2]  = r_rd.score;
            n_out[25:18] = r_rd.depth;
            n_out[27:26] = r_rd.bound;
            n_out[43:28] = r_rd.move;
            n_out[44]    = r_rd.move_null;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign n_clr_addr = o_sts.sweep_last ? '0 : r_clr_addr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_gen      <= '0;
        end else begin
            if (i_cmd.sweep) begin
                r_clr_addr <= n_clr_addr;
            end
            if (i_cmd.commit && o_sts.is_clear) begin
                r_gen <= '0;
            end else if (i_cfg_valid) begin
                r_gen <= i_cfg_data;
            end
        end
    end

    assign o_sts.is_clear   = (r_op == OP_CLEAR);
    assign o_sts.sweep_last = (r_clr_addr == IDX_W'(ENTRIES - 1));
    assign o_m_tdata        = r_out;

endmodule
